### rtl/assert_macros.svh
// Assertion helpers for the RTL, included by power_factor_calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds on every rising clock edge while reset is low.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that cond in one cycle is followed by nxt in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("assertion failed");

`endif

### rtl/pfc_pkg.sv
package pfc_pkg;

   // three phases plus the total, one lane each
   localparam int PHASE_COUNT  = 3;
   localparam int LANE_COUNT   = 4;
   localparam int TOTAL_LANE   = 3;
   localparam int FIELD_COUNT  = 12;
   localparam int LAMBDA_WIDTH = 16;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int MASK_WIDTH      = 3;
   localparam int LIMIT_WIDTH     = 15;
   localparam int MINIMUM_WIDTH   = 16;

   localparam logic [MASK_WIDTH-1:0]    MASK_RESET    = 3'd7;
   localparam logic [LIMIT_WIDTH-1:0]   LIMIT_RESET   = 15'd16383;
   localparam logic [MINIMUM_WIDTH-1:0] MINIMUM_RESET = 16'd1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THREE_WIRE  = 2'd0,
      CSR_PHASE_MASK  = 2'd1,
      CSR_LOAD_LIMIT  = 2'd2,
      CSR_APPARENT_MIN = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      LOAD_NONE = 2'd0,
      LOAD_IND  = 2'd1,
      LOAD_CAP  = 2'd2
   } load_type_type;

   // per-lane control that travels with the operands
   typedef struct packed {
      logic und;    // result undefined
      logic zero;   // result forced to a defined zero
      logic qpos;   // reactive power above zero
   } lane_flags_type;

   // one result item, lambda of lane 0 in the lowest bits
   typedef struct packed {
      logic [LANE_COUNT-1:0][1:0]              load;
      logic [LANE_COUNT-1:0]                   und;
      logic [LANE_COUNT-1:0][LAMBDA_WIDTH-1:0] lambda;
   } result_type;

endpackage

### rtl/power_factor_calculator.sv
// Throughput: one item per cycle while the output buffer is not full; the divider
// lanes are pipelined one quotient bit per stage.
// A two-entry output buffer lets the pipeline take items while a result waits.
// Reset (synchronous) empties the pipeline and output buffer and loads the register
// defaults: three-wire off, all phases enabled, load limit 16383, apparent minimum 1.
`include "assert_macros.svh"

module power_factor_calculator #(
   parameter int POWER_WIDTH      = 32,
   parameter int LAMBDA_FRAC_BITS = 14,
   localparam int REQ_WIDTH = ((pfc_pkg::FIELD_COUNT * POWER_WIDTH + 7) / 8) * 8,
   localparam int RSP_WIDTH = (($bits(pfc_pkg::result_type) + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // active_l1..l3, active_total, reactive_l1..l3, reactive_total,
   // apparent_l1..l3, apparent_total, zero fill
   input  logic [REQ_WIDTH-1:0]                  req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // lambda_l1..l3, lambda_total, undefined_l1..l3, undefined_total,
   // load_l1..l3, load_total, zero fill
   output logic [RSP_WIDTH-1:0]                  rsp_tdata,
   input  logic                                  csr_we,
   input  logic [pfc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pfc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int W = POWER_WIDTH;
   localparam int F = LAMBDA_FRAC_BITS;
   localparam int L = pfc_pkg::LANE_COUNT;
   localparam int STAGES = F + 3;   // input, prep, magnitude, F divider steps

   // configuration
   logic                                three_wire_ff;
   logic [pfc_pkg::MASK_WIDTH-1:0]      mask_ff;
   logic [pfc_pkg::LIMIT_WIDTH-1:0]     limit_ff;
   logic [pfc_pkg::MINIMUM_WIDTH-1:0]   minimum_ff;

   // pipeline control
   logic [STAGES-1:0]   valid_ff;
   logic [STAGES-1:0]   valid_in;
   logic                en;

   // input stage
   logic signed [W-1:0] p0_ff [L];
   logic signed [W-1:0] q0_ff [L];
   logic signed [W-1:0] s0_ff [L];

   // lanes
   logic signed [W+1:0]             lane_p   [L];
   logic signed [W+1:0]             lane_s   [L];
   pfc_pkg::lane_flags_type         lane_fl  [L];
   logic [pfc_pkg::LAMBDA_WIDTH-1:0] lane_lam [L];
   logic                            lane_und [L];
   pfc_pkg::load_type_type          lane_ld  [L];

   // output buffer
   pfc_pkg::result_type  result;
   pfc_pkg::result_type  head_ff;
   pfc_pkg::result_type  skid_ff;
   logic                 head_valid_ff;
   logic                 head_valid_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic                 push;
   logic                 pop;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         three_wire_ff <= 1'b0;
         mask_ff       <= pfc_pkg::MASK_RESET;
         limit_ff      <= pfc_pkg::LIMIT_RESET;
         minimum_ff    <= pfc_pkg::MINIMUM_RESET;
      end else if (csr_we) begin
         case (pfc_pkg::csr_index_type'(csr_index))
            pfc_pkg::CSR_THREE_WIRE: begin
               three_wire_ff <= csr_wdata[0];
            end
            pfc_pkg::CSR_PHASE_MASK: begin
               mask_ff <= csr_wdata[pfc_pkg::MASK_WIDTH-1:0];
            end
            pfc_pkg::CSR_LOAD_LIMIT: begin
               limit_ff <= csr_wdata[pfc_pkg::LIMIT_WIDTH-1:0];
            end
            pfc_pkg::CSR_APPARENT_MIN: begin
               minimum_ff <= csr_wdata[pfc_pkg::MINIMUM_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // whole pipeline advances unless the output buffer is full
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      valid_in = valid_ff;
      if (en) begin
         valid_in = {valid_ff[STAGES-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            p0_ff[i] <= req_tdata[i*W +: W];
            q0_ff[i] <= req_tdata[(L + i)*W +: W];
            s0_ff[i] <= req_tdata[(2*L + i)*W +: W];
         end
      end
   end

   pfc_prep #(
      .W (W)
   ) u_prep (
      .clock      (clock),
      .en         (en),
      .three_wire (three_wire_ff),
      .mask       (mask_ff),
      .minimum    (minimum_ff),
      .p_i        (p0_ff),
      .q_i        (q0_ff),
      .s_i        (s0_ff),
      .p_o        (lane_p),
      .s_o        (lane_s),
      .flags_o    (lane_fl)
   );

   for (genvar g = 0; g < L; g++) begin : g_lane
      pfc_lane #(
         .W (W),
         .F (F)
      ) u_lane (
         .clock    (clock),
         .en_abs   (en),
         .en_div   ({F{en}}),
         .p_i      (lane_p[g]),
         .s_i      (lane_s[g]),
         .flags_i  (lane_fl[g]),
         .limit    (limit_ff),
         .lambda_o (lane_lam[g]),
         .und_o    (lane_und[g]),
         .load_o   (lane_ld[g])
      );
   end

   // merge lane results into one item
   always_comb begin
      for (int i = 0; i < L; i++) begin
         result.lambda[i] = lane_lam[i];
         result.und[i]    = lane_und[i];
         result.load[i]   = lane_ld[i];
      end
   end

   assign push = en && valid_ff[STAGES-1];
   assign pop  = head_valid_ff && rsp_tready;

   // output buffer: head drives the port, skid holds one more item
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!head_valid_ff || pop) begin
         head_valid_in = skid_valid_ff || push;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || pop) begin
         head_ff <= skid_valid_ff ? skid_ff : result;
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(head_ff);

   `ASSERT_AT(a_skid_behind_head, clock, reset, skid_valid_ff |-> head_valid_ff)
   `ASSERT_NEXT(a_stall_keeps_skid, clock, reset, skid_valid_ff && !rsp_tready, skid_valid_ff)
   `ASSERT_AT(a_undef_total_clear, clock, reset, head_valid_ff && head_ff.und[pfc_pkg::TOTAL_LANE] |-> head_ff.lambda[pfc_pkg::TOTAL_LANE] == '0 && head_ff.load[pfc_pkg::TOTAL_LANE] == pfc_pkg::LOAD_NONE)

endmodule

### rtl/pfc_prep.sv
module pfc_prep #(
   parameter int W = 32
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic                                    three_wire,
   input  logic [pfc_pkg::MASK_WIDTH-1:0]          mask,
   input  logic [pfc_pkg::MINIMUM_WIDTH-1:0]       minimum,
   input  logic signed [W-1:0]                     p_i     [pfc_pkg::LANE_COUNT],
   input  logic signed [W-1:0]                     q_i     [pfc_pkg::LANE_COUNT],
   input  logic signed [W-1:0]                     s_i     [pfc_pkg::LANE_COUNT],
   output logic signed [W+1:0]                     p_o     [pfc_pkg::LANE_COUNT],
   output logic signed [W+1:0]                     s_o     [pfc_pkg::LANE_COUNT],
   output pfc_pkg::lane_flags_type                 flags_o [pfc_pkg::LANE_COUNT]
);

   localparam int SW = W + 2;

   logic [W-1:0]            s_mag  [pfc_pkg::PHASE_COUNT];
   logic                    ok     [pfc_pkg::PHASE_COUNT];
   logic signed [SW-1:0]    ssum;
   logic signed [SW-1:0]    p_in   [pfc_pkg::LANE_COUNT];
   logic signed [SW-1:0]    s_in   [pfc_pkg::LANE_COUNT];
   pfc_pkg::lane_flags_type fl_in  [pfc_pkg::LANE_COUNT];
   logic signed [SW-1:0]    p_ff   [pfc_pkg::LANE_COUNT];
   logic signed [SW-1:0]    s_ff   [pfc_pkg::LANE_COUNT];
   pfc_pkg::lane_flags_type fl_ff  [pfc_pkg::LANE_COUNT];

   // qualify phases, add up the apparent power of the valid ones
   always_comb begin
      ssum = '0;
      for (int i = 0; i < pfc_pkg::PHASE_COUNT; i++) begin
         s_mag[i] = s_i[i][W-1] ? W'(-s_i[i]) : W'(s_i[i]);
         ok[i]    = !three_wire && mask[i] && (s_i[i] != '0) && (s_mag[i] >= W'(minimum));
         if (ok[i]) begin
            ssum = ssum + SW'(s_i[i]);
         end
      end
      for (int i = 0; i < pfc_pkg::LANE_COUNT; i++) begin
         p_in[i]       = SW'(p_i[i]);
         s_in[i]       = SW'(s_i[i]);
         fl_in[i].qpos = !q_i[i][W-1] && (q_i[i] != '0);
         fl_in[i].zero = 1'b0;
         fl_in[i].und  = 1'b1;
      end
      for (int i = 0; i < pfc_pkg::PHASE_COUNT; i++) begin
         fl_in[i].und = !ok[i];
      end
      // total: own apparent power in three-wire mode, phase sum otherwise
      if (three_wire) begin
         fl_in[pfc_pkg::TOTAL_LANE].und = (s_i[pfc_pkg::TOTAL_LANE] == '0);
      end else begin
         s_in[pfc_pkg::TOTAL_LANE]       = ssum;
         fl_in[pfc_pkg::TOTAL_LANE].zero = (p_i[pfc_pkg::TOTAL_LANE] == '0);
         fl_in[pfc_pkg::TOTAL_LANE].und  = (p_i[pfc_pkg::TOTAL_LANE] != '0) && (ssum == '0);
      end
   end

   // register lane operands
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < pfc_pkg::LANE_COUNT; i++) begin
            p_ff[i]  <= p_in[i];
            s_ff[i]  <= s_in[i];
            fl_ff[i] <= fl_in[i];
         end
      end
   end

   assign p_o     = p_ff;
   assign s_o     = s_ff;
   assign flags_o = fl_ff;

endmodule

### rtl/pfc_lane.sv
module pfc_lane #(
   parameter int W = 32,
   parameter int F = 14
) (
   input  logic                                     clock,
   input  logic                                     en_abs,
   input  logic [F-1:0]                             en_div,
   input  logic signed [W+1:0]                      p_i,
   input  logic signed [W+1:0]                      s_i,
   input  pfc_pkg::lane_flags_type                  flags_i,
   input  logic [pfc_pkg::LIMIT_WIDTH-1:0]          limit,
   output logic [pfc_pkg::LAMBDA_WIDTH-1:0]         lambda_o,
   output logic                                     und_o,
   output pfc_pkg::load_type_type                   load_o
);

   localparam int DW = W + 1;   // operand magnitude
   localparam int XW = F + 18;  // signed result before truncation
   localparam int CW = F + 16;  // load limit compare

   logic [DW-1:0]           r_ff   [F+1];
   logic [DW-1:0]           ms_ff  [F+1];
   logic                    neg_ff [F+1];
   pfc_pkg::lane_flags_type fl_ff  [F+1];
   logic [F-1:0]            q_ff   [1:F];
   logic                    sat_ff [1:F];

   logic [DW-1:0]           r_in   [1:F];
   logic [F-1:0]            q_in   [1:F];
   logic                    sat_in [1:F];
   logic [DW:0]             t;
   logic                    ge;
   logic [F-1:0]            qp;

   logic [F:0]              qmag;
   logic [XW-1:0]           qext;
   logic [XW-1:0]           lam_w;
   logic                    dead;

   // one restoring division step per stage
   always_comb begin
      t  = '0;
      ge = 1'b0;
      qp = '0;
      for (int k = 1; k <= F; k++) begin
         t  = {r_ff[k-1], 1'b0};
         ge = (t >= {1'b0, ms_ff[k-1]});
         qp = (k == 1) ? '0 : q_ff[(k == 1) ? 1 : k-1];
         r_in[k] = ge ? DW'(t - {1'b0, ms_ff[k-1]}) : DW'(t);
         q_in[k] = {qp[F-2:0], ge};
         if (k == 1) begin
            sat_in[k] = (r_ff[0] >= ms_ff[0]);
         end else begin
            sat_in[k] = sat_ff[(k == 1) ? 1 : k-1];
         end
      end
   end

   // take magnitudes, then advance the divider stages
   always_ff @(posedge clock) begin
      if (en_abs) begin
         r_ff[0]   <= p_i[W+1] ? DW'(-p_i) : DW'(p_i);
         ms_ff[0]  <= s_i[W+1] ? DW'(-s_i) : DW'(s_i);
         neg_ff[0] <= p_i[W+1] ^ s_i[W+1];
         fl_ff[0]  <= flags_i;
      end
      for (int k = 1; k <= F; k++) begin
         if (en_div[k-1]) begin
            r_ff[k]   <= r_in[k];
            ms_ff[k]  <= ms_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            fl_ff[k]  <= fl_ff[k-1];
            q_ff[k]   <= q_in[k];
            sat_ff[k] <= sat_in[k];
         end
      end
   end

   // saturate, apply sign and classify the load; undefined or zero lanes give lambda 0 and no load
   always_comb begin
      qmag  = sat_ff[F] ? {1'b1, {F{1'b0}}} : {1'b0, q_ff[F]};
      qext  = XW'(qmag);
      lam_w = neg_ff[F] ? (~qext + XW'(1)) : qext;
      dead  = fl_ff[F].und || fl_ff[F].zero;
      und_o = fl_ff[F].und;
      if (dead) begin
         lambda_o = '0;
         load_o   = pfc_pkg::LOAD_NONE;
      end else begin
         lambda_o = lam_w[pfc_pkg::LAMBDA_WIDTH-1:0];
         if (CW'(qmag) < CW'(limit)) begin
            load_o = fl_ff[F].qpos ? pfc_pkg::LOAD_IND : pfc_pkg::LOAD_CAP;
         end else begin
            load_o = pfc_pkg::LOAD_NONE;
         end
      end
   end

endmodule
